// ===== sv/itoa_pkg.sv =====
// shared types, codes and tables for the integer to ascii formatter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // format codes carried in the func field
  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEXP = 2'd2;
  localparam logic [1:0] FUNC_HEX  = 2'd3;

  // digit store: ten bcd digits cover 4294967295
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IDX_W  = 4;
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = 5;
  localparam logic [CNT_W-1:0] CNT_INIT = 5'd31;

  // sequencer program counter
  localparam int STEP_W = 3;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_req_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DABBLE,
    OP_NORM,
    OP_SIGN,
    OP_PFX0,
    OP_PFXX,
    OP_DIGIT
  } op_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_NONE,
    JC_HEX,
    JC_CNT_NZ,
    JC_POS_NZ
  } jc_t;

  // one control word
  typedef struct packed {
    op_t               op;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic go;
    logic hex;
    logic cnt_nz;
    logic pos_nz;
  } dp_status_t;

  // upper-case hex character for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_UA + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/itoa_ucode_rom.sv =====
// microcode program of the formatter: one control word per step
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_ucode_rom (
  input  wire logic [itoa_pkg::STEP_W-1:0] step,
  output itoa_pkg::ucw_t                   ucw
);

  // program: load, binary to bcd loop, find top digit, sign, prefix, digits;
  // the last step falls through to step zero by wrapping
  always_comb begin
    unique case (step)
      3'd0: ucw = '{op: itoa_pkg::OP_LOAD,   jc: itoa_pkg::JC_NONE,   target: 3'd0};
      3'd1: ucw = '{op: itoa_pkg::OP_NOP,    jc: itoa_pkg::JC_HEX,    target: 3'd3};
      3'd2: ucw = '{op: itoa_pkg::OP_DABBLE, jc: itoa_pkg::JC_CNT_NZ, target: 3'd2};
      3'd3: ucw = '{op: itoa_pkg::OP_NORM,   jc: itoa_pkg::JC_NONE,   target: 3'd0};
      3'd4: ucw = '{op: itoa_pkg::OP_SIGN,   jc: itoa_pkg::JC_NONE,   target: 3'd0};
      3'd5: ucw = '{op: itoa_pkg::OP_PFX0,   jc: itoa_pkg::JC_NONE,   target: 3'd0};
      3'd6: ucw = '{op: itoa_pkg::OP_PFXX,   jc: itoa_pkg::JC_NONE,   target: 3'd0};
      3'd7: ucw = '{op: itoa_pkg::OP_DIGIT,  jc: itoa_pkg::JC_POS_NZ, target: 3'd7};
      default: ucw = '{op: itoa_pkg::OP_NOP, jc: itoa_pkg::JC_NONE,   target: 3'd0};
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/itoa_datapath.sv =====
// datapath of the formatter: magnitude, bcd digit store, counters, output register
// depends on itoa_pkg; driven by control words from itoa_ucode_rom
`timescale 1ns / 1ps
`default_nettype none

module itoa_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire itoa_pkg::ucw_t       ucw,
  input  wire logic                 in_valid,
  input  wire itoa_pkg::in_req_t    in_req,
  output itoa_pkg::dp_status_t      status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output itoa_pkg::out_req_t        out_req
);

  logic [1:0]                       func_r, func_nxt;
  logic                             neg_r, neg_nxt;
  logic [itoa_pkg::VALUE_W-1:0]     mag_r, mag_nxt;
  logic [itoa_pkg::NUM_DIGITS-1:0][3:0] dig_r, dig_nxt;
  logic [itoa_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [itoa_pkg::DIG_IDX_W-1:0]   pos_r, pos_nxt;
  logic                             out_valid_r, out_valid_nxt;
  itoa_pkg::out_req_t               out_req_r, out_req_nxt;

  logic [itoa_pkg::NUM_DIGITS-1:0][3:0] dig_adj;
  logic                             in_hex;
  logic                             in_neg;
  logic                             want;
  logic                             out_free;
  logic [7:0]                       emit_char;

  assign in_hex = (in_req.func == itoa_pkg::FUNC_HEXP) || (in_req.func == itoa_pkg::FUNC_HEX);
  assign in_neg = (in_req.func == itoa_pkg::FUNC_SDEC) && in_req.value[31];
  assign out_free = !out_valid_r || !out_stall;

  // add-3 correction of every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
      dig_adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
  end

  // character request of the current step
  always_comb begin
    want      = 1'b0;
    emit_char = itoa_pkg::hex_char(dig_r[pos_r]);
    case (ucw.op)
      itoa_pkg::OP_SIGN: begin
        want      = neg_r;
        emit_char = itoa_pkg::CH_MINUS;
      end
      itoa_pkg::OP_PFX0: begin
        want      = (func_r == itoa_pkg::FUNC_HEXP);
        emit_char = itoa_pkg::CH_ZERO;
      end
      itoa_pkg::OP_PFXX: begin
        want      = (func_r == itoa_pkg::FUNC_HEXP);
        emit_char = itoa_pkg::CH_X;
      end
      itoa_pkg::OP_DIGIT: begin
        want = 1'b1;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  // step completion and jump conditions
  always_comb begin
    status.hex    = (func_r == itoa_pkg::FUNC_HEXP) || (func_r == itoa_pkg::FUNC_HEX);
    status.cnt_nz = (cnt_r != '0);
    status.pos_nz = (pos_r != '0);
    if (ucw.op == itoa_pkg::OP_LOAD) begin
      status.go = in_valid;
    end else begin
      status.go = !want || out_free;
    end
  end

  // working registers, next values
  always_comb begin
    func_nxt = func_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    case (ucw.op)
      itoa_pkg::OP_LOAD: begin
        func_nxt = in_req.func;
        neg_nxt  = in_neg;
        mag_nxt  = in_neg ? (~in_req.value + 32'd1) : in_req.value;
        dig_nxt  = in_hex ? {8'd0, in_req.value} : '0;
        cnt_nxt  = itoa_pkg::CNT_INIT;
      end
      itoa_pkg::OP_DABBLE: begin
        // whole digit store and magnitude shift left by one; top digit stays below eight
        {dig_nxt, mag_nxt} = {dig_adj[itoa_pkg::NUM_DIGITS-1][2:0],
                              dig_adj[itoa_pkg::NUM_DIGITS-2:0], mag_r, 1'b0};
        cnt_nxt = cnt_r - 5'd1;
      end
      itoa_pkg::OP_NORM: begin
        pos_nxt = '0;
        for (int i = 1; i < itoa_pkg::NUM_DIGITS; i++) begin
          if (dig_r[i] != 4'd0) begin
            pos_nxt = itoa_pkg::DIG_IDX_W'(i);
          end
        end
      end
      itoa_pkg::OP_DIGIT: begin
        if (out_free && status.pos_nz) begin
          pos_nxt = pos_r - 4'd1;
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;
    if (want && out_free) begin
      out_valid_nxt         = 1'b1;
      out_req_nxt.character = emit_char;
      out_req_nxt.last      = (ucw.op == itoa_pkg::OP_DIGIT) && (pos_r == '0);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    dig_r     <= dig_nxt;
    cnt_r     <= cnt_nxt;
    pos_r     <= pos_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// integer to ascii formatter: top level with the microcode step counter
// depends on itoa_pkg, itoa_ucode_rom and itoa_datapath
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   in_valid / in_stall / in_req carry one request: a 32-bit value and a
//   format code (signed decimal, unsigned decimal, hex with 0x, plain hex).
//   out_valid / out_stall / out_req return the text one ascii character per
//   request, last set on the final character; runs are 1 to 11 characters.
//   A request is taken only while the sequencer sits on its load step.
//   Decimal requests run a 32-step binary to bcd loop on the shared digit
//   store; hex requests skip it. A new request is taken only after the last
//   character of the current one has entered the output register.
//   When out_stall is high a valid character holds in the output register
//   and the sequencer waits on its next character step; nothing is dropped.
//   Reset (rst_n low, synchronous) returns the sequencer to the load step
//   and empties the output register; no state carries between requests.
module integer_to_ascii_formatter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire itoa_pkg::in_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output itoa_pkg::out_req_t     out_req
);

  logic [itoa_pkg::STEP_W-1:0] step_r, step_nxt;
  itoa_pkg::ucw_t              ucw;
  itoa_pkg::dp_status_t        status;
  logic                        take_jump;

  itoa_ucode_rom u_rom (
    .step (step_r),
    .ucw  (ucw)
  );

  itoa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ucw       (ucw),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  assign in_stall = (ucw.op != itoa_pkg::OP_LOAD);

  // jump condition select
  always_comb begin
    unique case (ucw.jc)
      itoa_pkg::JC_NONE:   take_jump = 1'b0;
      itoa_pkg::JC_HEX:    take_jump = status.hex;
      itoa_pkg::JC_CNT_NZ: take_jump = status.cnt_nz;
      itoa_pkg::JC_POS_NZ: take_jump = status.pos_nz;
      default:             take_jump = 1'b0;
    endcase
  end

  // step counter: hold, jump or fall through (wraps to the load step)
  always_comb begin
    step_nxt = step_r;
    if (status.go) begin
      step_nxt = take_jump ? ucw.target : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire
